@@ hdl/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg - shared types and constants of the first-fit heap allocator
// Word and address widths, request and status codes, register indexes and
// the sequencer state type.
// ----------------------------------------------------------------------------
package ffha_pkg;

  // Width of one heap word (size or flag word of a block header).
  localparam int unsigned WORD_W = 10;
  // Width of absolute and returned addresses.
  localparam int unsigned ADDR_W = 16;
  // Width of the configuration register index.
  localparam int unsigned CFG_IDX_W = 1;

  // Flag word value that marks a block as free.
  localparam logic [WORD_W-1:0] FLAG_FREE = 10'd1;
  localparam logic [WORD_W-1:0] FLAG_USED = 10'd0;
  // Largest size word that a merged block may carry.
  localparam logic [WORD_W:0]   SIZE_MAX  = 11'd1023;
  // Heap size after reset.
  localparam logic [WORD_W-1:0] HEAP_LENGTH_RESET = 10'd512;

  typedef enum logic [1:0] {
    REQ_INIT  = 2'd0,
    REQ_ALLOC = 2'd1,
    REQ_FREE  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    STATUS_OK     = 1'b0,
    STATUS_NO_FIT = 1'b1
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAP_BASE   = 1'b0,
    CFG_HEAP_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT_SIZE,
    S_INIT_FLAG,
    S_A_HEAD,
    S_A_FLAG,
    S_A_CHECK,
    S_A_SPLIT,
    S_A_REST_SIZE,
    S_A_REST_FLAG,
    S_F_MARK,
    S_C_HEAD,
    S_C_FLAG,
    S_C_CHECK,
    S_C_NEXT_HEAD,
    S_C_MERGE,
    S_RESP
  } state_e;

endpackage

@@ hdl/ffha_ram.sv @@
// ----------------------------------------------------------------------------
// ffha_ram - generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/first_fit_heap_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit - first-fit heap manager with coalescing
// Keeps block headers in an on-chip word store and serves init, allocate and
// free requests, one result item per request item.
// ----------------------------------------------------------------------------
// The heap lives in one synchronous RAM of HEAP_WORDS ten-bit words. Every
// block starts with a size word and a flag word (1 means free). An init item
// writes one free block over the whole heap. An allocate item walks the
// headers from word 0 and takes the first free block that holds the
// requested size plus two header words; each block visited takes a size read,
// a flag read and a check, and a split rewrites the size word and writes a
// new header behind the fit, so its time grows with the number of blocks in
// front of the fit. A free item marks the flag and then makes one coalescing
// pass over the whole heap: each block passed takes a size read, a flag read
// and a check, and each neighbor looked at adds a header read and a merge
// step. The walks are bounded by the shared RAM port: one read per cycle.
// Items are taken one at a time; the result sits in an output register, so
// the next item is accepted while a result still waits to be taken. The
// store is not cleared at reset: an init item must come before any allocate
// or free. Configuration writes (heap base, heap length) are expected only
// while no item is in flight.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_WORDS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ffha_pkg::ADDR_W-1:0]        cfg_data_i,

  // Request items.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [9:0] alloc_size, [25:10] block_address
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type

  // Result items.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] result_address
  output logic [0:0]  m_axis_tuser_o    // [0] status
);

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  // Pointer width: holds an in-heap offset plus one block size.
  localparam int unsigned SW = ((AW > ffha_pkg::WORD_W) ? AW : ffha_pkg::WORD_W) + 1;
  localparam logic [SW-1:0] DEPTH_S  = SW'(HEAP_WORDS);
  localparam logic [16:0]   DEPTH_17 = 17'(HEAP_WORDS);

  localparam int unsigned WW = ffha_pkg::WORD_W;

  // Configuration registers.
  logic [ffha_pkg::ADDR_W-1:0] heap_base_q;
  logic [WW-1:0]               heap_length_q;

  // Sequencer state and walk registers.
  ffha_pkg::state_e state_q, state_d;
  logic [SW-1:0]  p_q, p_d;
  logic [WW-1:0]  s_q, s_d;
  logic [WW-1:0]  ns_q, ns_d;
  logic           rdok_q, rdok_d;
  logic [WW:0]    need_q, need_d;
  logic [15:0]    baddr_q, baddr_d;
  logic [15:0]    res_addr_q, res_addr_d;
  ffha_pkg::status_e res_st_q, res_st_d;

  // Output register.
  logic           out_valid_q, out_valid_d;
  logic [15:0]    out_addr_q, out_addr_d;
  ffha_pkg::status_e out_st_q, out_st_d;

  // RAM port.
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WW-1:0] ram_wdata, ram_rdata;

  // Derived values.
  logic [SW-1:0] span_w;
  logic [SW-1:0] p_next_w;     // p + s: next header
  logic [SW-1:0] p_inc_w;      // p + 1: flag word
  logic [SW-1:0] n_inc_w;      // (p + s) + 1: neighbor flag word
  logic [SW-1:0] rest_idx_w;   // p + need: split-off header
  logic [SW-1:0] rest_inc_w;
  logic [WW:0]   rest_w;
  logic [WW:0]   merged_w;
  logic          flag_free_w;
  logic [15:0]   hdr_w;
  logic [16:0]   mark_idx_w;
  logic          in_accept;
  logic          load_out;

  assign span_w     = (SW'(heap_length_q) < DEPTH_S) ? SW'(heap_length_q) : DEPTH_S;
  assign p_next_w   = p_q + SW'(s_q);
  assign p_inc_w    = p_q + SW'(1);
  assign n_inc_w    = p_next_w + SW'(1);
  assign rest_idx_w = p_q + SW'(need_q);
  assign rest_inc_w = rest_idx_w + SW'(1);
  assign rest_w     = {1'b0, s_q} - need_q;
  assign merged_w   = {1'b0, s_q} + {1'b0, ns_q};
  assign flag_free_w = rdok_q && (ram_rdata == ffha_pkg::FLAG_FREE);
  assign hdr_w      = baddr_q - 16'd2 - heap_base_q;
  assign mark_idx_w = {1'b0, hdr_w} + 17'd1;

  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration is always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q   <= '0;
      heap_length_q <= ffha_pkg::HEAP_LENGTH_RESET;
    end else if (cfg_valid_i) begin
      case (ffha_pkg::cfg_idx_e'(cfg_index_i))
        ffha_pkg::CFG_HEAP_BASE:   heap_base_q   <= cfg_data_i;
        ffha_pkg::CFG_HEAP_LENGTH: heap_length_q <= cfg_data_i[WW-1:0];
        default: ;
      endcase
    end
  end

  ffha_ram #(
    .WIDTH (WW),
    .DEPTH (HEAP_WORDS)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    s_q        <= s_d;
    ns_q       <= ns_d;
    rdok_q     <= rdok_d;
    need_q     <= need_d;
    baddr_q    <= baddr_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_st_q   <= out_st_d;
  end

  always_comb begin
    state_d    = state_q;
    p_d        = p_q;
    s_d        = s_q;
    ns_d       = ns_q;
    rdok_d     = rdok_q;
    need_d     = need_q;
    baddr_d    = baddr_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    s_axis_tready_o = 1'b0;
    load_out   = 1'b0;

    case (state_q)
      ffha_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          need_d     = {1'b0, s_axis_tdata_i[9:0]} + 11'd2;
          baddr_d    = s_axis_tdata_i[25:10];
          res_addr_d = '0;
          res_st_d   = ffha_pkg::STATUS_OK;
          p_d        = '0;
          case (ffha_pkg::req_e'(s_axis_tuser_i))
            ffha_pkg::REQ_INIT:  state_d = ffha_pkg::S_INIT_SIZE;
            ffha_pkg::REQ_ALLOC: state_d = ffha_pkg::S_A_HEAD;
            ffha_pkg::REQ_FREE: begin
              state_d = (s_axis_tdata_i[25:10] == 16'd0) ? ffha_pkg::S_RESP
                                                        : ffha_pkg::S_F_MARK;
            end
            default: state_d = ffha_pkg::S_RESP;
          endcase
        end
      end

      ffha_pkg::S_INIT_SIZE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(0);
        ram_wdata = heap_length_q;
        state_d   = ffha_pkg::S_INIT_FLAG;
      end

      ffha_pkg::S_INIT_FLAG: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(1);
        ram_wdata = ffha_pkg::FLAG_FREE;
        state_d   = ffha_pkg::S_RESP;
      end

      // Allocate walk: read size, read flag, decide.
      ffha_pkg::S_A_HEAD: begin
        if (p_q < span_w) begin
          ram_re    = 1'b1;
          ram_raddr = p_q[AW-1:0];
          state_d   = ffha_pkg::S_A_FLAG;
        end else begin
          res_st_d = ffha_pkg::STATUS_NO_FIT;
          state_d  = ffha_pkg::S_RESP;
        end
      end

      ffha_pkg::S_A_FLAG: begin
        s_d = ram_rdata;
        if (ram_rdata == '0) begin
          // A zero-size header ends the walk.
          res_st_d = ffha_pkg::STATUS_NO_FIT;
          state_d  = ffha_pkg::S_RESP;
        end else begin
          // A flag word beyond the store reads as used.
          rdok_d    = p_inc_w < DEPTH_S;
          ram_re    = p_inc_w < DEPTH_S;
          ram_raddr = p_inc_w[AW-1:0];
          state_d   = ffha_pkg::S_A_CHECK;
        end
      end

      ffha_pkg::S_A_CHECK: begin
        if (flag_free_w && ({1'b0, s_q} >= need_q)) begin
          ram_we     = 1'b1;
          ram_waddr  = p_inc_w[AW-1:0];
          ram_wdata  = ffha_pkg::FLAG_USED;
          res_addr_d = heap_base_q + 16'(p_q) + 16'd2;
          state_d    = (rest_w > 11'd2) ? ffha_pkg::S_A_SPLIT : ffha_pkg::S_RESP;
        end else begin
          p_d     = p_next_w;
          state_d = ffha_pkg::S_A_HEAD;
        end
      end

      ffha_pkg::S_A_SPLIT: begin
        ram_we    = 1'b1;
        ram_waddr = p_q[AW-1:0];
        ram_wdata = need_q[WW-1:0];
        state_d   = ffha_pkg::S_A_REST_SIZE;
      end

      ffha_pkg::S_A_REST_SIZE: begin
        ram_we    = rest_idx_w < DEPTH_S;
        ram_waddr = rest_idx_w[AW-1:0];
        ram_wdata = rest_w[WW-1:0];
        state_d   = ffha_pkg::S_A_REST_FLAG;
      end

      ffha_pkg::S_A_REST_FLAG: begin
        ram_we    = rest_inc_w < DEPTH_S;
        ram_waddr = rest_inc_w[AW-1:0];
        ram_wdata = ffha_pkg::FLAG_FREE;
        state_d   = ffha_pkg::S_RESP;
      end

      // Free: mark the flag word, then one coalescing pass from word 0.
      ffha_pkg::S_F_MARK: begin
        ram_we    = mark_idx_w < DEPTH_17;
        ram_waddr = mark_idx_w[AW-1:0];
        ram_wdata = ffha_pkg::FLAG_FREE;
        p_d       = '0;
        state_d   = ffha_pkg::S_C_HEAD;
      end

      ffha_pkg::S_C_HEAD: begin
        if (p_q < span_w) begin
          ram_re    = 1'b1;
          ram_raddr = p_q[AW-1:0];
          state_d   = ffha_pkg::S_C_FLAG;
        end else begin
          state_d = ffha_pkg::S_RESP;
        end
      end

      ffha_pkg::S_C_FLAG: begin
        s_d = ram_rdata;
        if (ram_rdata == '0) begin
          state_d = ffha_pkg::S_RESP;
        end else begin
          rdok_d    = p_inc_w < DEPTH_S;
          ram_re    = p_inc_w < DEPTH_S;
          ram_raddr = p_inc_w[AW-1:0];
          state_d   = ffha_pkg::S_C_CHECK;
        end
      end

      ffha_pkg::S_C_CHECK: begin
        if (flag_free_w && (p_next_w < span_w)) begin
          ram_re    = 1'b1;
          ram_raddr = p_next_w[AW-1:0];
          state_d   = ffha_pkg::S_C_NEXT_HEAD;
        end else begin
          p_d     = p_next_w;
          state_d = ffha_pkg::S_C_HEAD;
        end
      end

      ffha_pkg::S_C_NEXT_HEAD: begin
        ns_d      = ram_rdata;
        rdok_d    = n_inc_w < DEPTH_S;
        ram_re    = n_inc_w < DEPTH_S;
        ram_raddr = n_inc_w[AW-1:0];
        state_d   = ffha_pkg::S_C_MERGE;
      end

      ffha_pkg::S_C_MERGE: begin
        if (flag_free_w && (ns_q != '0) && (merged_w <= ffha_pkg::SIZE_MAX)) begin
          // Grow this block and look at the same header again, so that it
          // can swallow the following free blocks as well.
          ram_we    = 1'b1;
          ram_waddr = p_q[AW-1:0];
          ram_wdata = merged_w[WW-1:0];
        end else begin
          p_d = p_next_w;
        end
        state_d = ffha_pkg::S_C_HEAD;
      end

      ffha_pkg::S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = ffha_pkg::S_IDLE;
        end
      end

      default: state_d = ffha_pkg::S_IDLE;
    endcase
  end

  // Output register: loaded when a result is ready and the slot is free or draining.
  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_st_d    = out_st_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_addr_d  = res_addr_q;
      out_st_d    = res_st_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_addr_q;
  assign m_axis_tuser_o  = out_st_q;

`ifndef SYNTHESIS
  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !s_axis_tready_o)
    else $error("request accepted while another is in work");

  // The RAM is never written while waiting for a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffha_pkg::S_IDLE) |-> !ram_we)
    else $error("heap write while idle");

  // A failed allocation always reports address zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ffha_pkg::STATUS_NO_FIT))
      |-> (m_axis_tdata_o == 16'd0))
    else $error("no-fit result with nonzero address");

  // A header read is only issued inside the heap span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ffha_pkg::S_A_HEAD) || (state_q == ffha_pkg::S_C_HEAD)) && ram_re
      |-> (p_q < span_w))
    else $error("header read beyond the heap span");

  // A result is only loaded when the output slot is free or draining.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwrote a pending output");
`endif

endmodule

@@ tb/tb_first_fit_heap_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_unit - self-checking bench for the heap allocator
// Drives init, allocate, free and no-operation items through the request
// stream and mirrors the heap headers in a behavioral image. Each result item
// is checked against the reply predicted for the matching request, under
// random sender gaps, receiver stalls and several heap base/length settings.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_unit;

  localparam int unsigned HEAP_DEPTH = 512;
  // The limit allows a free item with a full coalescing pass over many tiny
  // blocks for every item, plus stalls.
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [ffha_pkg::ADDR_W-1:0] addr;
    ffha_pkg::status_e           status;
  } reply_t;

  // Behavioral image of the heap headers plus the replies still owed.
  class heap_checker;
    logic [ffha_pkg::WORD_W-1:0] heap_image [HEAP_DEPTH];
    logic [ffha_pkg::ADDR_W-1:0] base;
    logic [ffha_pkg::WORD_W-1:0] length;
    reply_t                      replies_due [$];
    int unsigned errors, replies_seen, requests, inits, fits, no_fits, frees, merges;

    function new();
      base   = '0;
      length = ffha_pkg::HEAP_LENGTH_RESET;
      foreach (heap_image[i]) heap_image[i] = '0;
    endfunction

    function int unsigned rd(int unsigned i);
      return (i < HEAP_DEPTH) ? int'(heap_image[i]) : 0;
    endfunction

    function void wr(int unsigned i, int unsigned v);
      if (i < HEAP_DEPTH) heap_image[i] = v[ffha_pkg::WORD_W-1:0];
    endfunction

    function void set_register(ffha_pkg::cfg_idx_e idx, logic [ffha_pkg::ADDR_W-1:0] v);
      if (idx == ffha_pkg::CFG_HEAP_BASE) base = v;
      else length = v[ffha_pkg::WORD_W-1:0];
    endfunction

    // Applies one accepted request to the image and queues its reply.
    function reply_t apply_request(ffha_pkg::req_e kind, logic [ffha_pkg::WORD_W-1:0] size,
                                   logic [ffha_pkg::ADDR_W-1:0] baddr);
      reply_t r;
      int unsigned lim, p, s, n, ns, need;
      logic [ffha_pkg::ADDR_W-1:0] hdr;
      bit found;
      r.addr   = '0;
      r.status = ffha_pkg::STATUS_OK;
      lim = (length < HEAP_DEPTH) ? length : HEAP_DEPTH;
      requests++;
      case (kind)
        ffha_pkg::REQ_INIT: begin
          wr(0, length);
          wr(1, ffha_pkg::FLAG_FREE);
          inits++;
        end
        ffha_pkg::REQ_ALLOC: begin
          need  = size + 2;
          p     = 0;
          found = 1'b0;
          while (!found && p < lim) begin
            s = rd(p);
            // A zero size word ends the walk.
            if (s == 0) break;
            if (rd(p + 1) == ffha_pkg::FLAG_FREE && s >= need) begin
              found = 1'b1;
              wr(p + 1, ffha_pkg::FLAG_USED);
              // Split only when more than a bare header would remain.
              if (s - need > 2) begin
                wr(p, need);
                wr(p + need, s - need);
                wr(p + need + 1, ffha_pkg::FLAG_FREE);
              end
              r.addr = 16'(base + p + 2);
            end else begin
              p += s;
            end
          end
          if (found) fits++;
          else begin
            r.status = ffha_pkg::STATUS_NO_FIT;
            no_fits++;
          end
        end
        ffha_pkg::REQ_FREE: begin
          if (baddr != 0) begin
            hdr = baddr - 16'd2 - base;
            wr(hdr + 1, ffha_pkg::FLAG_FREE);
            frees++;
            // One pass; a free block keeps absorbing free followers.
            p = 0;
            while (p < lim) begin
              s = rd(p);
              if (s == 0) break;
              if (rd(p + 1) == ffha_pkg::FLAG_FREE) begin
                n = p + s;
                if (n < lim) begin
                  ns = rd(n);
                  if (rd(n + 1) == ffha_pkg::FLAG_FREE && ns != 0 &&
                      s + ns <= ffha_pkg::SIZE_MAX) begin
                    wr(p, s + ns);
                    merges++;
                    continue;
                  end
                end
                p = n;
              end else begin
                p += s;
              end
            end
          end
        end
        default: ;
      endcase
      replies_due.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [ffha_pkg::ADDR_W-1:0] addr, logic [0:0] st);
      reply_t e;
      replies_seen++;
      if (replies_due.size() == 0) begin
        $error("unexpected result item: result_address=%0h status=%0d", addr, st);
        errors++;
        return;
      end
      e = replies_due.pop_front();
      if (addr !== e.addr) begin
        $error("result_address: expected %0h, actual %0h", e.addr, addr);
        errors++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ffha_pkg::ADDR_W-1:0]    cfg_data_i = '0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [31:0]                    s_axis_tdata_i = '0;
  logic [1:0]                     s_axis_tuser_i = '0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [15:0]                    m_axis_tdata_o;
  logic [0:0]                     m_axis_tuser_o;

  heap_checker                 sb;
  logic [ffha_pkg::ADDR_W-1:0] live [$];     // payload addresses currently allocated
  longint                      cycle_count = 0;
  int unsigned                 settings = 0;
  int unsigned                 hold_requests = 0;
  int unsigned                 hold_served = 0;
  int unsigned                 hold_left = 0;

  first_fit_heap_allocator_unit #(.HEAP_WORDS(HEAP_DEPTH)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: check every accepted item, then choose the next tready.
  // A requested hold-off keeps tready low for a long counted stretch;
  // otherwise the stall pattern rotates through four modes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_reply(m_axis_tdata_o, m_axis_tuser_o);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready_i <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served <= hold_served + 1;
        hold_left <= HOLD_CYCLES;
        m_axis_tready_i <= 1'b0;
      end else begin
        case ((cycle_count >> 9) % 4)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(0, 1));
          2: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ((cycle_count % 7) >= 3);
        endcase
      end
    end
  end

  task automatic write_heap_regs(input logic [ffha_pkg::ADDR_W-1:0] base,
                                 input logic [ffha_pkg::WORD_W-1:0] len);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= ffha_pkg::CFG_HEAP_BASE;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(ffha_pkg::CFG_HEAP_BASE, base);
    cfg_index_i <= ffha_pkg::CFG_HEAP_LENGTH;
    cfg_data_i  <= {6'd0, len};
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(ffha_pkg::CFG_HEAP_LENGTH, {6'd0, len});
    cfg_valid_i <= 1'b0;
    settings++;
  endtask

  // Offers one request item and keeps tvalid high after acceptance, so the
  // next item can follow back to back.
  task automatic push_request(input ffha_pkg::req_e kind,
                              input logic [ffha_pkg::WORD_W-1:0] size,
                              input logic [ffha_pkg::ADDR_W-1:0] baddr, output reply_t rep);
    int idx;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= kind;
    s_axis_tdata_i  <= {6'd0, baddr, size};
    do @(posedge clk_i); while (!s_axis_tready_o);
    rep = sb.apply_request(kind, size, baddr);
    if (kind == ffha_pkg::REQ_INIT) live.delete();
    else if (kind == ffha_pkg::REQ_ALLOC && rep.status == ffha_pkg::STATUS_OK)
      live.push_back(rep.addr);
    else if (kind == ffha_pkg::REQ_FREE) begin
      for (idx = 0; idx < live.size(); idx++) begin
        if (live[idx] == baddr) begin
          live.delete(idx);
          break;
        end
      end
    end
  endtask

  task automatic idle_sender(input int unsigned n);
    s_axis_tvalid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every owed reply has come back, then lets the block go quiet.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.replies_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One heap setting: mostly allocate/free traffic on live blocks, with some
  // re-inits, ignored frees, frees that land outside the store and no-ops.
  task automatic run_phase(input logic [ffha_pkg::ADDR_W-1:0] base,
                           input logic [ffha_pkg::WORD_W-1:0] len,
                           input int unsigned count, input bit gaps, input bit hold,
                           input bit pause_mid);
    int unsigned sent, burst, pick, cap, idx;
    logic [ffha_pkg::WORD_W-1:0] size;
    logic [ffha_pkg::ADDR_W-1:0] addr;
    reply_t rep;
    settle();
    write_heap_regs(base, len);
    if (hold) hold_requests <= hold_requests + 1;
    push_request(ffha_pkg::REQ_INIT, '0, '0, rep);
    cap  = (len / 6 > 0) ? len / 6 : 1;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          push_request(ffha_pkg::REQ_INIT, 10'($urandom), 16'($urandom), rep);
          sent++;
        end else if (pick < 6) begin
          push_request(ffha_pkg::REQ_NOP, 10'($urandom), 16'($urandom), rep);
        end else if (pick < 8) begin
          push_request(ffha_pkg::REQ_FREE, 10'($urandom), 16'd0, rep);
        end else if (pick < 11) begin
          // Flag word beyond the store: the flag write is dropped.
          addr = 16'($urandom_range(HEAP_DEPTH - 1, 65535)) + 16'd2 + base;
          push_request(ffha_pkg::REQ_FREE, 10'($urandom), addr, rep);
          sent++;
        end else if (pick < 52 && live.size() != 0) begin
          idx = $urandom_range(0, live.size() - 1);
          push_request(ffha_pkg::REQ_FREE, 10'($urandom), live[idx], rep);
          sent++;
        end else begin
          case ($urandom_range(0, 19))
            0: size = 10'($urandom);
            1: size = 10'($urandom_range(0, len));
            default: size = 10'($urandom_range(0, cap));
          endcase
          push_request(ffha_pkg::REQ_ALLOC, size, 16'($urandom), rep);
          sent++;
        end
      end
      if (pause_mid && sent >= count / 2) begin
        pause_mid = 1'b0;
        settle();
      end else if (gaps && $urandom_range(0, 2) != 0) begin
        idle_sender($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    reply_t rep;
    logic [ffha_pkg::ADDR_W-1:0] a0, a1, a2, a3;
    int ph;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on a 40-word heap whose base makes later addresses wrap.
    write_heap_regs(16'hFFF6, 10'd40);
    push_request(ffha_pkg::REQ_NOP, 10'h3FF, 16'hFFFF, rep);
    push_request(ffha_pkg::REQ_INIT, '0, '0, rep);
    push_request(ffha_pkg::REQ_ALLOC, 10'd0, '0, rep);
    a0 = rep.addr;
    push_request(ffha_pkg::REQ_ALLOC, 10'd1023, '0, rep);
    push_request(ffha_pkg::REQ_ALLOC, 10'd10, '0, rep);
    a1 = rep.addr;
    push_request(ffha_pkg::REQ_ALLOC, 10'd5, '0, rep);
    a2 = rep.addr;
    push_request(ffha_pkg::REQ_FREE, '0, a1, rep);
    push_request(ffha_pkg::REQ_FREE, '0, 16'd0, rep);
    push_request(ffha_pkg::REQ_FREE, '0, 16'hFFFF + 16'd2 + 16'hFFF6, rep);
    push_request(ffha_pkg::REQ_ALLOC, 10'd3, '0, rep);
    a3 = rep.addr;
    push_request(ffha_pkg::REQ_FREE, '0, a0, rep);
    push_request(ffha_pkg::REQ_FREE, '0, a3, rep);
    push_request(ffha_pkg::REQ_FREE, '0, a2, rep);
    // Near-exact fit leaves no split, exact fit, then one word too many.
    push_request(ffha_pkg::REQ_ALLOC, 10'd37, '0, rep);
    push_request(ffha_pkg::REQ_FREE, '0, rep.addr, rep);
    push_request(ffha_pkg::REQ_ALLOC, 10'd38, '0, rep);
    push_request(ffha_pkg::REQ_FREE, '0, rep.addr, rep);
    push_request(ffha_pkg::REQ_ALLOC, 10'd39, '0, rep);
    push_request(ffha_pkg::REQ_NOP, '0, '0, rep);

    // Zero size word at the heap start: init with length 0, then widen the
    // length so that every walk stops at that header.
    settle();
    write_heap_regs(16'h0000, 10'd0);
    push_request(ffha_pkg::REQ_INIT, '0, '0, rep);
    settle();
    write_heap_regs(16'h0000, 10'd5);
    push_request(ffha_pkg::REQ_ALLOC, 10'd1, '0, rep);
    push_request(ffha_pkg::REQ_FREE, '0, 16'hFFF2, rep);

    // Random part across several settings, the extremes among them.
    run_phase(16'h0000, 10'd512, 150, 1'b1, 1'b0, 1'b0);
    run_phase(16'hFFFF, 10'd3, 60, 1'b1, 1'b0, 1'b0);
    run_phase(16'($urandom), 10'd1023, 120, 1'b0, 1'b1, 1'b0);
    for (ph = 0; ph < 8; ph++) begin
      run_phase(16'($urandom), 10'($urandom_range(16, 128)), 130, ph[0], 1'b0, ph == 3);
    end

    settle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d requests over %0d heap settings: %0d inits, %0d fits, %0d no-fits,",
             sb.requests, settings, sb.inits, sb.fits, sb.no_fits);
    $display("%0d frees with %0d merges; %0d result items checked, %0d mismatches.",
             sb.frees, sb.merges, sb.replies_seen, sb.errors);
    if (sb.errors == 0 && sb.replies_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ffha_pkg.sv
hdl/ffha_ram.sv
hdl/first_fit_heap_allocator_unit.sv
tb/tb_first_fit_heap_allocator_unit.sv
